// File: hdl/search_position_cache_macros.svh
// ----------------------------------------------------------------------------
// search_position_cache_macros
// Assertion macros shared by the position cache RTL.
// ----------------------------------------------------------------------------
`ifndef SEARCH_POSITION_CACHE_MACROS_SVH
`define SEARCH_POSITION_CACHE_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property checked at every rising edge outside reset.
`define SPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside reset.
`define SPC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SPC_ASSERT(lbl, clk, rst, prop, msg)
`define SPC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// File: hdl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types, constants and score helpers of the search position cache.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int unsigned ENTRIES_DEF = 1024;
   localparam int unsigned KEY_W = 64;
   localparam int unsigned MOD_BITS_PER_STEP = 8;
   localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS_PER_STEP;
   localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

   localparam logic [14:0] MATE_LIMIT_RST = 15'd30000;
   localparam logic signed [9:0] REPLACE_BONUS = 10'sd7;
   localparam logic signed [9:0] PV_BONUS = 10'sd2;
   localparam logic signed [9:0] DEPTH_MARGIN = 10'sd4;

   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;

   typedef enum logic [2:0] {
      FUNC_STORE  = 3'd0,
      FUNC_PROBE  = 3'd1,
      FUNC_SEARCH = 3'd2,
      FUNC_EVAL   = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]         func;
      logic [KEY_W-1:0]   key;
      logic signed [7:0]  req_depth;
      logic signed [15:0] score_in;
      logic [7:0]         ply;
      logic [15:0]        move_in;
      logic               pv_flag;
      logic [1:0]         bound_in;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [7:0]  hit_depth;
      logic signed [15:0] hit_score;
      logic [15:0]        hit_move;
      logic [1:0]         hit_bound;
   } rsp_type;

   // One table slot as it sits in memory: full key over the 42-bit entry.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [1:0]         bound;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic signed [7:0]  depth;
   } slot_type;

   localparam int unsigned SLOT_W = $bits(slot_type);

   // Mate scores move away from zero by ply on store and back on fetch,
   // then clamp to the 16-bit range.
   function automatic logic signed [15:0] mate_adjust(
      input logic signed [15:0] score,
      input logic [7:0]         ply,
      input logic [14:0]        bound,
      input logic               toward_zero
   );
      logic signed [17:0] s;
      logic signed [17:0] p;
      logic signed [17:0] b;
      logic signed [17:0] r;
      s = $signed({{2{score[15]}}, score});
      p = $signed({10'd0, ply});
      b = $signed({3'd0, bound});
      if (s < -b) begin
         r = toward_zero ? s + p : s - p;
      end else if (s > b) begin
         r = toward_zero ? s - p : s + p;
      end else begin
         r = s;
      end
      if (r > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (r < -18'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

endpackage

// File: hdl/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/spc_index_unit.sv
// ----------------------------------------------------------------------------
// spc_index_unit
// Reduces a 64-bit key modulo the slot count to give the slot index.
// ----------------------------------------------------------------------------
`include "search_position_cache_macros.svh"

module spc_index_unit #(
   parameter int unsigned ENTRIES = spc_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [spc_pkg::KEY_W-1:0]      key,
   output logic                           done,
   output logic [$clog2(ENTRIES)-1:0]     index
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

   logic unit_busy;

   generate
      if (IS_POW2) begin : g_mask
         // A power-of-two slot count needs only the low key bits.
         assign done      = start;
         assign index     = key[IDX_W-1:0];
         assign unit_busy = 1'b0;
      end else begin : g_reduce
         localparam logic [IDX_W:0] MOD_N = (IDX_W + 1)'(ENTRIES);
         localparam logic [spc_pkg::MOD_CNT_W-1:0] CNT_LAST =
            spc_pkg::MOD_CNT_W'(spc_pkg::MOD_STEPS - 1);

         logic [IDX_W-1:0]                 rem_ff;
         logic [IDX_W-1:0]                 rem_in;
         logic [spc_pkg::KEY_W-1:0]        shift_ff;
         logic [spc_pkg::MOD_CNT_W-1:0]    cnt_ff;
         logic                             busy_ff;
         logic                             done_ff;
         logic [IDX_W:0]                   trial;

         // Long division by a constant, a byte of the key per cycle,
         // most significant bits first.
         always_comb begin
            rem_in = rem_ff;
            trial  = '0;
            for (int b = 0; b < int'(spc_pkg::MOD_BITS_PER_STEP); b++) begin
               trial = {rem_in, shift_ff[spc_pkg::KEY_W-1-b]};
               if (trial >= MOD_N) begin
                  trial = trial - MOD_N;
               end
               rem_in = trial[IDX_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= '0;
               end else if (busy_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CNT_LAST) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff   <= '0;
               shift_ff <= key;
            end else if (busy_ff) begin
               rem_ff   <= rem_in;
               shift_ff <= shift_ff << spc_pkg::MOD_BITS_PER_STEP;
            end
         end

         assign done      = done_ff;
         assign index     = rem_ff;
         assign unit_busy = busy_ff;
      end
   endgenerate

   `SPC_ASSERT(a_no_start_while_busy, clock, reset, unit_busy |-> !start,
      "index unit restarted while still reducing a key")
   `SPC_ASSERT(a_done_not_with_busy, clock, reset, done |-> !unit_busy || start,
      "index unit reported done while still reducing")

endmodule

// File: hdl/search_position_cache.sv
// ----------------------------------------------------------------------------
// search_position_cache
// Direct-mapped transposition table: store, probes and clear over one RAM.
// ----------------------------------------------------------------------------
// Usage: drive req_data and raise start; the operation is taken at a rising
// edge where start is high and busy is low. Each operation, clear included,
// returns exactly one result on rsp_data, marked by rsp_strobe for a single
// cycle. The receiver cannot stall, so the result must be taken then.
// Timing: every slot access is a read of the indexed slot followed by an
// optional write back, through one RAM with a registered read. With a
// power-of-two slot count the slot is read at the transfer; busy stays high
// only through the execute state, and the registered result strobe comes
// with the return to idle, when a new operation can already be taken.
// Other slot counts add a key reduction (one key byte per cycle) before the
// read. Clear walks the RAM one slot per cycle, then gives its result.
// Reset starts the same clearing pass with busy high and no result;
// csr_we/csr_wdata write the mate score limit at any time, but it should
// only be changed while no operation is in flight.
// ----------------------------------------------------------------------------
`include "search_position_cache_macros.svh"

module search_position_cache #(
   parameter int unsigned ENTRIES = spc_pkg::ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output spc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [14:0]      csr_wdata
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ENTRIES - 1);

   spc_pkg::state_type state_ff, state_in;
   spc_pkg::req_type   req_ff;
   spc_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [14:0]        mate_limit_ff;

   logic               accept;
   logic               unit_start;
   logic               unit_done;
   logic [IDX_W-1:0]   unit_index;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [IDX_W-1:0]   ram_raddr;
   spc_pkg::slot_type  ram_wdata;
   logic [spc_pkg::SLOT_W-1:0] ram_rdata;

   spc_pkg::slot_type  slot;
   spc_pkg::slot_type  new_slot;
   logic               key_hit;
   logic               replace;
   logic               hit;
   logic signed [9:0]  new_rank;
   logic signed [9:0]  old_rank;

   assign accept     = start && (state_ff == spc_pkg::ST_IDLE);
   assign busy       = (state_ff != spc_pkg::ST_IDLE);
   assign unit_start = accept && (req_data.func != spc_pkg::FUNC_CLEAR);

   spc_index_unit #(
      .ENTRIES(ENTRIES)
   ) u_index (
      .clock(clock),
      .reset(reset),
      .start(unit_start),
      .key  (req_data.key),
      .done (unit_done),
      .index(unit_index)
   );

   spc_ram #(
      .WIDTH(spc_pkg::SLOT_W),
      .DEPTH(ENTRIES)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Slot evaluation on the registered read data.
   always_comb begin
      slot     = spc_pkg::slot_type'(ram_rdata);
      key_hit  = (slot.key == req_ff.key);
      new_rank = 10'(req_ff.req_depth) + spc_pkg::REPLACE_BONUS
               + (req_ff.pv_flag ? spc_pkg::PV_BONUS : 10'sd0);
      old_rank = 10'(slot.depth) - spc_pkg::DEPTH_MARGIN;
      replace  = (req_ff.bound_in == spc_pkg::BOUND_EXACT) || !key_hit
              || (new_rank > old_rank);

      new_slot.key   = req_ff.key;
      new_slot.bound = req_ff.bound_in;
      new_slot.move  = req_ff.move_in;
      new_slot.score = spc_pkg::mate_adjust(req_ff.score_in, req_ff.ply,
                                            mate_limit_ff, 1'b0);
      new_slot.depth = req_ff.req_depth;

      case (req_ff.func)
         spc_pkg::FUNC_PROBE:  hit = key_hit;
         spc_pkg::FUNC_SEARCH: hit = key_hit && (slot.depth >= req_ff.req_depth)
                                     && (req_ff.ply != 8'd0);
         spc_pkg::FUNC_EVAL:   hit = key_hit;
         default:              hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      clr_idx_in    = clr_idx_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = new_slot;
      ram_raddr     = unit_index;

      case (state_ff)
         spc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.func == spc_pkg::FUNC_CLEAR) begin
                  clr_idx_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = spc_pkg::ST_CLEAR;
               end else if (unit_done) begin
                  idx_in   = unit_index;
                  state_in = spc_pkg::ST_EXEC;
               end else begin
                  state_in = spc_pkg::ST_INDEX;
               end
            end
         end
         spc_pkg::ST_INDEX: begin
            if (unit_done) begin
               idx_in   = unit_index;
               state_in = spc_pkg::ST_EXEC;
            end
         end
         spc_pkg::ST_EXEC: begin
            ram_we        = (req_ff.func == spc_pkg::FUNC_STORE) && replace;
            rsp_strobe_in = 1'b1;
            if (hit) begin
               rsp_in.found     = 1'b1;
               rsp_in.hit_depth = slot.depth;
               rsp_in.hit_score = (req_ff.func == spc_pkg::FUNC_PROBE) ? slot.score :
                                  spc_pkg::mate_adjust(slot.score, req_ff.ply,
                                                       mate_limit_ff, 1'b1);
               rsp_in.hit_move  = slot.move;
               rsp_in.hit_bound = slot.bound;
            end
            state_in = spc_pkg::ST_IDLE;
         end
         spc_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_ff;
            ram_wdata = '0;
            if (clr_idx_ff == CLR_LAST) begin
               // Only an explicit clear returns a result; the reset pass does not.
               rsp_strobe_in = clr_rsp_ff;
               clr_rsp_in    = 1'b0;
               state_in      = spc_pkg::ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = spc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spc_pkg::ST_CLEAR;
         clr_idx_ff    <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         mate_limit_ff <= spc_pkg::MATE_LIMIT_RST;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            mate_limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `SPC_ASSERT(a_exec_gives_result, clock, reset,
      (state_ff == spc_pkg::ST_EXEC) |=> rsp_strobe_ff,
      "slot operation finished without a result transfer")
   `SPC_ASSERT(a_result_when_idle, clock, reset,
      rsp_strobe_ff |-> (state_ff == spc_pkg::ST_IDLE),
      "result transfer outside the idle state")
   `SPC_ASSERT_NEVER(a_no_stray_write, clock, reset,
      ram_we && (state_ff == spc_pkg::ST_IDLE || state_ff == spc_pkg::ST_INDEX),
      "slot RAM written while no operation owns it")
   `SPC_ASSERT(a_clear_ends, clock, reset,
      (state_ff == spc_pkg::ST_CLEAR && clr_idx_ff == CLR_LAST)
         |=> (state_ff == spc_pkg::ST_IDLE),
      "clearing pass did not end at the last slot")

endmodule

// File: tb/spc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spc_result_checker
// Watches the request, result and register ports of the position cache,
// keeps its own copy of the table and the mate bound, works out the result
// of every accepted request and compares each result strobe with it.
// ----------------------------------------------------------------------------
module spc_result_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  spc_pkg::req_type    req_data,
   input  logic                rsp_strobe,
   input  spc_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic [14:0]         csr_wdata,
   output int unsigned         fail_count,
   output int unsigned         pending,
   output int unsigned         hit_count
);
   import spc_pkg::*;

   localparam int unsigned SLOTS = ENTRIES_DEF;
   localparam int REPLACE_ADD = 7;
   localparam int PV_ADD = 2;
   localparam int OLD_DEPTH_SUB = 4;

   slot_type    slots [SLOTS];
   logic [14:0] mate_lim;
   rsp_type     expected_rsp_q [$];
   int unsigned fails;
   int unsigned hits;

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Scores beyond the mate bound move away from zero by ply when written
   // and back toward zero when read by the search and eval probes.
   function automatic int mate_shift(input int s, input int p, input bit outward);
      int b;
      b = int'(mate_lim);
      if (s < -b) begin
         s = outward ? s - p : s + p;
      end else if (s > b) begin
         s = outward ? s + p : s - p;
      end
      return clamp16(s);
   endfunction

   function automatic rsp_type predict_cache_op(input req_type r);
      rsp_type  res;
      slot_type cur;
      int       idx;
      int       d;
      int       sd;
      int       sc;
      int       p;
      logic     key_hit;
      res = '0;
      idx = int'(r.key % SLOTS);
      cur = slots[idx];
      d = $signed(r.req_depth);
      sd = $signed(cur.depth);
      sc = $signed(cur.score);
      p = int'(r.ply);
      key_hit = (cur.key == r.key);
      case (r.func)
         FUNC_STORE: begin
            if (r.bound_in == BOUND_EXACT || !key_hit ||
                d + REPLACE_ADD + PV_ADD * int'(r.pv_flag) > sd - OLD_DEPTH_SUB) begin
               slots[idx].key   = r.key;
               slots[idx].depth = r.req_depth;
               slots[idx].score = 16'(mate_shift($signed(r.score_in), p, 1'b1));
               slots[idx].move  = r.move_in;
               slots[idx].bound = r.bound_in;
            end
         end
         FUNC_PROBE: begin
            if (key_hit) begin
               res.found = 1'b1;
               res.hit_score = cur.score;
            end
         end
         FUNC_SEARCH: begin
            if (key_hit && sd >= d && r.ply != 8'd0) begin
               res.found = 1'b1;
               res.hit_score = 16'(mate_shift(sc, p, 1'b0));
            end
         end
         FUNC_EVAL: begin
            if (key_hit) begin
               res.found = 1'b1;
               res.hit_score = 16'(mate_shift(sc, p, 1'b0));
            end
         end
         FUNC_CLEAR: begin
            foreach (slots[i]) slots[i] = '0;
         end
         default: ;
      endcase
      if (res.found) begin
         res.hit_depth = cur.depth;
         res.hit_move  = cur.move;
         res.hit_bound = cur.bound;
      end
      return res;
   endfunction

   task automatic compare_rsp(input rsp_type got);
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         $error("result strobe with no request outstanding");
         fails++;
         return;
      end
      want = expected_rsp_q.pop_front();
      if (got.found !== want.found) begin
         $error("found: expected %0d, actual %0d", want.found, got.found);
         fails++;
      end
      if (got.hit_depth !== want.hit_depth) begin
         $error("hit_depth: expected %0d, actual %0d",
                $signed(want.hit_depth), $signed(got.hit_depth));
         fails++;
      end
      if (got.hit_score !== want.hit_score) begin
         $error("hit_score: expected %0d, actual %0d",
                $signed(want.hit_score), $signed(got.hit_score));
         fails++;
      end
      if (got.hit_move !== want.hit_move) begin
         $error("hit_move: expected 0x%04h, actual 0x%04h", want.hit_move, got.hit_move);
         fails++;
      end
      if (got.hit_bound !== want.hit_bound) begin
         $error("hit_bound: expected %0d, actual %0d", want.hit_bound, got.hit_bound);
         fails++;
      end
      if (want.found) hits++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (slots[i]) slots[i] = '0;
         mate_lim = MATE_LIMIT_RST;
         expected_rsp_q.delete();
         fails = 0;
         hits = 0;
      end else begin
         // A result and the next transfer can share an edge; the result
         // always belongs to an earlier request.
         if (rsp_strobe) compare_rsp(rsp_data);
         if (start && !busy) expected_rsp_q.push_back(predict_cache_op(req_data));
         if (csr_we) mate_lim = csr_wdata;
      end
      fail_count <= fails;
      pending <= expected_rsp_q.size();
      hit_count <= hits;
   end

endmodule

// File: tb/tb_search_position_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_search_position_cache
// Drives directed and random cache operations in bursts under several mate
// bound settings; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_search_position_cache;
   import spc_pkg::*;

   localparam int STALL_LIMIT = 8000;
   localparam int PHASE_OPS = 330;
   localparam int POOL_SIZE = 16;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [14:0] csr_wdata;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned hit_count;

   int          stall_cycles;
   int          burst_left;
   int          ops_sent;
   int          clears_sent;
   int          settings_used;
   int          mate_cfg;
   logic [63:0] key_pool [POOL_SIZE];

   search_position_cache dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   spc_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .hit_count  (hit_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clears and the reset pass run with no transfer and no result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic req_type make_op(
      input logic [2:0]  func,
      input logic [63:0] key,
      input int          depth,
      input int          score,
      input int          ply,
      input logic [15:0] move,
      input logic        pv,
      input logic [1:0]  bound
   );
      req_type r;
      r.func      = func;
      r.key       = key;
      r.req_depth = 8'(depth);
      r.score_in  = 16'(score);
      r.ply       = 8'(ply);
      r.move_in   = move;
      r.pv_flag   = pv;
      r.bound_in  = bound;
      return r;
   endfunction

   // Most operations hit a small pool of keys that share a few slots, so
   // stores, replacements and probes interact.
   function automatic req_type random_op();
      req_type r;
      int      roll;
      int      mag;
      roll = $urandom_range(0, 199);
      if (roll < 2) r.func = FUNC_CLEAR;
      else if (roll < 6) r.func = 3'($urandom_range(5, 7));
      else if (roll < 86) r.func = FUNC_STORE;
      else if (roll < 116) r.func = FUNC_PROBE;
      else if (roll < 160) r.func = FUNC_SEARCH;
      else r.func = FUNC_EVAL;
      if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else r.key = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: r.score_in = 16'($urandom);
         3, 4, 5, 6: begin
            mag = mate_cfg + $urandom_range(0, 4) - 2;
            if (mag > 32767) mag = 32767;
            if (mag < 0) mag = 0;
            r.score_in = 16'($urandom_range(0, 1) ? mag : -mag);
         end
         7: r.score_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         8: r.score_in = 16'($urandom_range(0, 200) - 100);
         default: begin
            mag = 32767 - $urandom_range(0, 300);
            r.score_in = 16'($urandom_range(0, 1) ? mag : -mag);
         end
      endcase
      if ($urandom_range(0, 9) < 6) r.req_depth = 8'($urandom_range(0, 40) - 10);
      else r.req_depth = 8'($urandom);
      case ($urandom_range(0, 9))
         0, 1: r.ply = 8'd0;
         2: r.ply = 8'd255;
         3, 4: r.ply = 8'($urandom);
         default: r.ply = 8'($urandom_range(1, 60));
      endcase
      r.move_in  = 16'($urandom);
      r.pv_flag  = 1'($urandom);
      r.bound_in = 2'($urandom_range(0, 3));
      return r;
   endfunction

   task automatic send_op(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      ops_sent++;
      if (r.func == FUNC_CLEAR) clears_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mate_limit(input int value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= 15'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      mate_cfg = value;
      settings_used++;
   endtask

   initial begin
      logic [63:0] key_a;
      logic [63:0] key_a2;
      logic [63:0] key_b;
      int          bound_list [5];
      int          base_idx [3];

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      burst_left = 0;
      ops_sent = 0;
      clears_sent = 0;
      settings_used = 1;
      mate_cfg = int'(MATE_LIMIT_RST);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      key_a  = 64'h0123_4567_89AB_C0DE;
      key_a2 = key_a ^ (64'h1 << 40);
      key_b  = 64'hFFFF_FFFF_FFFF_FFFF;

      // Directed part under the reset mate bound.
      send_op(make_op(FUNC_PROBE, 64'd0, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_STORE, key_a, 127, 32767, 255, 16'hFFFF, 1'b1, BOUND_EXACT));
      send_op(make_op(FUNC_PROBE, key_a, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_EVAL, key_a, 0, 0, 10, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_SEARCH, key_a, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_SEARCH, key_a, 127, 0, 1, 16'h0, 1'b0, BOUND_EXACT));
      // Shallower non-exact store of the same key leaves the slot alone.
      send_op(make_op(FUNC_STORE, key_a, -128, -5, 0, 16'h1234, 1'b0, BOUND_LOWER));
      send_op(make_op(FUNC_PROBE, key_a, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_STORE, key_a2, -128, -30001, 3, 16'h8001, 1'b0, BOUND_UPPER));
      send_op(make_op(FUNC_SEARCH, key_a2, -128, 0, 255, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_PROBE, key_a, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_STORE, key_b, 5, -32768, 200, 16'h00FF, 1'b1, BOUND_LOWER));
      send_op(make_op(FUNC_EVAL, key_b, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_STORE, key_b, 100, 30000, 7, 16'h5A5A, 1'b0, 2'd3));
      send_op(make_op(FUNC_SEARCH, key_b, 100, 0, 9, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_STORE, key_b, 0, 30001, 1, 16'hA5A5, 1'b1, BOUND_UPPER));
      send_op(make_op(FUNC_STORE, key_b, -1, 30001, 1, 16'hC3C3, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_EVAL, key_b, 0, 0, 1, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(3'd5, key_b, 1, 2, 3, 16'h0004, 1'b1, BOUND_UPPER));
      send_op(make_op(3'd6, key_a, -1, -2, 9, 16'hFFFF, 1'b0, 2'd3));
      send_op(make_op(3'd7, 64'd0, 0, 0, 0, 16'h0, 1'b1, BOUND_LOWER));
      send_op(make_op(FUNC_CLEAR, key_a, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_PROBE, key_a2, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_PROBE, 64'd0, 0, 0, 0, 16'h0, 1'b0, BOUND_EXACT));
      send_op(make_op(FUNC_SEARCH, 64'd0, 0, 0, 1, 16'h0, 1'b0, BOUND_EXACT));

      // Key pool: a few shared slots with differing upper key bits, plus the
      // all-zero and all-one keys.
      foreach (base_idx[i]) base_idx[i] = $urandom_range(0, ENTRIES_DEF - 1);
      foreach (key_pool[i]) begin
         key_pool[i] = {$urandom, $urandom};
         key_pool[i][9:0] = 10'(base_idx[i % 3]);
      end
      key_pool[0] = 64'd0;
      key_pool[1] = key_b;
      key_pool[2] = {$urandom, $urandom} & ~64'h3FF;

      bound_list[0] = 0;
      bound_list[1] = 32767;
      bound_list[2] = 100;
      bound_list[3] = $urandom_range(1, 32766);
      bound_list[4] = int'(MATE_LIMIT_RST);
      foreach (bound_list[p]) begin
         write_mate_limit(bound_list[p]);
         repeat (PHASE_OPS) send_op(random_op());
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d operations, %0d of them clears, with %0d probe hits",
               ops_sent, clears_sent, hit_count);
      $display("across %0d mate bound settings, zero and full scale included.",
               settings_used);
      if (pending != 0) $error("%0d results never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/spc_pkg.sv
hdl/spc_ram.sv
hdl/spc_index_unit.sv
hdl/search_position_cache.sv
tb/spc_result_checker.sv
tb/tb_search_position_cache.sv
